@@ hw/rtl/trt_pkg.sv @@
// Shared types and constants for the tickless repeating event timer.
// Used by the channel interfaces, the slot cell and the top level.
package trt_pkg;

  localparam int INTERVAL_W    = 10;
  localparam int CPM_W         = 15;
  localparam int NSPC_W        = 20;
  localparam int PERIOD_W      = 24;
  localparam int COUNTER_W     = 25;
  localparam int TOTAL_W       = 32;
  localparam int TIME_W        = 64;
  localparam int FIRED_W       = 4;
  localparam int PERIOD_REGS   = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;
  localparam int MUL_A_W       = 32;
  localparam int MUL_B_W       = 20;
  localparam int MUL_W         = MUL_A_W + MUL_B_W;

  localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_MS = INTERVAL_W'(1000);
  localparam logic [MUL_B_W-1:0]    NS_PER_MS       = MUL_B_W'(1000000);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_MS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NS_PER_COUNT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SLOT0  = CFG_IDX_W'(2);

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Token passed from cell to cell during a tick scan.
  typedef struct packed {
    logic                  go;
    logic [INTERVAL_W-1:0] min_ms;
    logic [FIRED_W-1:0]    fired;
  } link_t;

endpackage

@@ hw/rtl/trt_ifs.sv @@
// Valid/ready channel interfaces for command items and result items.
// Depends on trt_pkg for field widths.
interface trt_cmd_if import trt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [COUNTER_W-1:0] counter_value;

  modport source (output valid, action, counter_value, input ready);
  modport sink   (input valid, action, counter_value, output ready);
endinterface

interface trt_result_if import trt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIRED_W-1:0]    fired_mask;
  logic [INTERVAL_W-1:0] next_interval_ms;
  logic [COUNTER_W-1:0]  reload_value;
  logic [TOTAL_W-1:0]    total_ms;
  logic [TIME_W-1:0]     time_ns;

  modport source (output valid, fired_mask, next_interval_ms, reload_value, total_ms,
                  time_ns, input ready);
  modport sink   (input valid, fired_mask, next_interval_ms, reload_value, total_ms,
                  time_ns, output ready);
endinterface

@@ hw/rtl/trt_slot_cell.sv @@
// One event slot: holds its period and elapsed time, updates the elapsed time when the
// scan token passes, and forwards the running minimum and fired bits. Uses trt_pkg.
module trt_slot_cell import trt_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_wr_t               cfg,
  input  logic [INTERVAL_W-1:0] interval,
  input  link_t                 link_in,
  output link_t                 link_out
);

  logic [PERIOD_W-1:0]   period;
  logic [PERIOD_W-1:0]   elapsed;
  logic [PERIOD_W-1:0]   elapsed_next;
  logic                  enabled;
  logic [PERIOD_W:0]     el_sum;
  logic [PERIOD_W+1:0]   el_diff;
  logic                  fire;
  logic                  wrap_clr;
  logic [PERIOD_W-1:0]   remain;
  logic [FIRED_W-1:0]    fire_bit;
  link_t                 link_next;

  generate
    if (IDX < PERIOD_REGS) begin : g_period
      always_ff @(posedge clk) begin
        if (rst) begin
          period <= '0;
        end else if (cfg.we && cfg.index == CFG_IDX_W'(REG_PERIOD_SLOT0 + IDX)) begin
          period <= cfg.data[PERIOD_W-1:0];
        end
      end
      assign fire_bit = FIRED_W'(fire) << IDX;
    end else begin : g_no_period
      // Slots beyond the period registers stay disabled.
      assign period   = '0;
      assign fire_bit = '0;
    end
  endgenerate

  always_comb begin
    enabled  = (period != '0);
    el_sum   = {1'b0, elapsed} + (PERIOD_W+1)'(interval);
    el_diff  = {1'b0, el_sum} - (PERIOD_W+2)'(period);
    fire     = enabled && !el_diff[PERIOD_W+1];
    // After the period is taken off, an elapsed time still at or above it is dropped.
    wrap_clr = fire && (el_diff[PERIOD_W:0] >= {1'b0, period});
    if (wrap_clr) begin
      elapsed_next = '0;
    end else if (fire) begin
      elapsed_next = el_diff[PERIOD_W-1:0];
    end else begin
      elapsed_next = el_sum[PERIOD_W-1:0];
    end
    remain = period - elapsed_next;

    link_next.go     = link_in.go;
    link_next.fired  = link_in.fired | (link_in.go ? fire_bit : '0);
    link_next.min_ms = link_in.min_ms;
    if (enabled && remain < PERIOD_W'(link_in.min_ms)) begin
      link_next.min_ms = remain[INTERVAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    link_out.min_ms <= link_next.min_ms;
    link_out.fired  <= link_next.fired;
    if (rst) begin
      elapsed     <= '0;
      link_out.go <= 1'b0;
    end else begin
      link_out.go <= link_next.go;
      if (link_in.go && enabled) begin
        elapsed <= elapsed_next;
      end
    end
  end

endmodule

@@ hw/rtl/tickless_repeating_event_timer_unit.sv @@
// Tickless repeating event timer. A tick item walks the scan token through the slot cell
// chain one cell per cycle, then the shared 32x20 multiplier forms the reload. A read item
// makes three passes through the shared multiplier and then the final add. Only one item
// is in flight: the next item is accepted in the cycle after its result is loaded, and a
// result is loaded only once a previous one has left the output register.
// Synchronous active-high reset: total 0, interval 1000 ms, all slots cleared and off.
module tickless_repeating_event_timer_unit import trt_pkg::*; #(
  parameter int SLOTS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  trt_cmd_if.sink               cmd,
  trt_result_if.source          result
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_MREL  = 8'b0000_0100,
    S_REL   = 8'b0000_1000,
    S_DIFF  = 8'b0001_0000,
    S_MDIFF = 8'b0010_0000,
    S_MTOT  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t                state;
  logic [CPM_W-1:0]      counts_per_ms;
  logic [NSPC_W-1:0]     ns_per_count;
  logic [TOTAL_W-1:0]    total_ms;
  logic [INTERVAL_W-1:0] cur_interval;
  logic                  launch;
  logic                  action_q;
  logic [COUNTER_W-1:0]  counter_q;
  logic [FIRED_W-1:0]    fired_q;
  logic [MUL_W-1:0]      mul_q;
  logic [COUNTER_W-1:0]  reload_q;
  logic [COUNTER_W-1:0]  diff_q;
  logic [TIME_W-1:0]     time_q;
  logic                  sum_pending;
  logic                  res_valid;
  logic [FIRED_W-1:0]    res_fired;
  logic [INTERVAL_W-1:0] res_interval;
  logic [COUNTER_W-1:0]  res_reload;
  logic [TOTAL_W-1:0]    res_total;
  logic [TIME_W-1:0]     res_time;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [MUL_W-1:0]      mul_p;
  cfg_wr_t               cfg_wr;
  link_t                 link [SLOTS+1];

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  always_comb begin
    link[0].go     = launch;
    link[0].min_ms = MAX_INTERVAL_MS;
    link[0].fired  = '0;
  end

  generate
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      trt_slot_cell #(.IDX(k)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .cfg      (cfg_wr),
        .interval (cur_interval),
        .link_in  (link[k]),
        .link_out (link[k+1])
      );
    end
  endgenerate

  // Shared multiplier: reload product, elapsed counts to ns, and total ms to ns.
  always_comb begin
    case (state)
      S_MREL: begin
        mul_a = MUL_A_W'(cur_interval);
        mul_b = MUL_B_W'(counts_per_ms);
      end
      S_MDIFF: begin
        mul_a = MUL_A_W'(diff_q);
        mul_b = ns_per_count;
      end
      default: begin
        mul_a = total_ms;
        mul_b = NS_PER_MS;
      end
    endcase
    mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  assign cmd.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_ms <= CPM_W'(1);
      ns_per_count  <= NSPC_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COUNTS_PER_MS: counts_per_ms <= cfg_data[CPM_W-1:0];
        REG_NS_PER_COUNT:  ns_per_count  <= cfg_data[NSPC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      total_ms     <= '0;
      cur_interval <= MAX_INTERVAL_MS;
      launch       <= 1'b0;
      sum_pending  <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      launch <= (state == S_IDLE) && cmd.valid && !cmd.action;
      if (state == S_OUT && !sum_pending && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            action_q  <= cmd.action;
            counter_q <= cmd.counter_value;
            fired_q   <= '0;
            time_q    <= '0;
            if (!cmd.action) begin
              total_ms <= total_ms + TOTAL_W'(cur_interval);
              state    <= S_SCAN;
            end else begin
              state <= S_MREL;
            end
          end
        end
        S_SCAN: begin
          if (link[SLOTS].go) begin
            cur_interval <= link[SLOTS].min_ms;
            fired_q      <= link[SLOTS].fired;
            state        <= S_MREL;
          end
        end
        S_MREL: begin
          mul_q <= mul_p;
          state <= S_REL;
        end
        S_REL: begin
          // A zero product gives a zero reload rather than wrapping.
          reload_q <= (mul_q[COUNTER_W-1:0] == '0) ? '0 :
                      mul_q[COUNTER_W-1:0] - COUNTER_W'(1);
          state    <= action_q ? S_DIFF : S_OUT;
        end
        S_DIFF: begin
          diff_q <= (counter_q > reload_q) ? '0 : reload_q - counter_q;
          state  <= S_MDIFF;
        end
        S_MDIFF: begin
          mul_q <= mul_p;
          state <= S_MTOT;
        end
        S_MTOT: begin
          time_q      <= TIME_W'(mul_q);
          mul_q       <= mul_p;
          sum_pending <= 1'b1;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (sum_pending) begin
            time_q      <= time_q + TIME_W'(mul_q);
            sum_pending <= 1'b0;
          end else if (!res_valid || result.ready) begin
            res_fired    <= fired_q;
            res_interval <= cur_interval;
            res_reload   <= reload_q;
            res_total    <= total_ms;
            res_time     <= time_q;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid            = res_valid;
  assign result.fired_mask       = res_fired;
  assign result.next_interval_ms = res_interval;
  assign result.reload_value     = res_reload;
  assign result.total_ms         = res_total;
  assign result.time_ns          = res_time;

  a_interval_range: assert property (@(posedge clk) disable iff (rst)
    cur_interval != '0 && cur_interval <= MAX_INTERVAL_MS)
    else $error("programmed interval out of range");

  a_read_keeps_total: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && cmd.action) |=> $stable(total_ms))
    else $error("read item changed the millisecond total");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    link[SLOTS].go |-> state == S_SCAN)
    else $error("scan token left the chain outside a scan");

  a_fired_no_time: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.fired_mask != '0) |-> result.time_ns == '0)
    else $error("tick result carries a nonzero time");

endmodule
